### design/lkv_pkg.sv
// Shared types and constants of the LRU key/value cache.
`default_nettype none

package lkv_pkg;

	// Field widths fixed by the item format.
	localparam int KEY_W = 16;
	localparam int VAL_W = 32;
	localparam int CAP_W = 4;

	// Default geometry.
	localparam int DEF_ENTRIES = 8;
	localparam int IN_DEPTH = 2;
	localparam int OUT_DEPTH = 4;

	// Capacity register value after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

	// Action codes.
	localparam logic ACT_ADD = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	// One request item.
	typedef struct packed {
		logic action;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] write_value;
	} req_t;

	// One result item.
	typedef struct packed {
		logic hit;
		logic [VAL_W-1:0] read_value;
	} rsp_t;

endpackage

`default_nettype wire

### design/lkv_fifo.sv
// Small synchronous queue used in front of and behind the cache core.
`default_nettype none

module lkv_fifo
	import lkv_pkg::*;
#(
	parameter int WIDTH = $bits(req_t),
	parameter int DEPTH = IN_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire logic [WIDTH-1:0]             wdata,
	output logic                              full,
	input  wire logic                         pop,
	output logic [WIDTH-1:0]                  rdata,
	output logic                              empty,
	output logic [$clog2(DEPTH+1)-1:0]        count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [CNW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNW'(DEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;
	assign rdata = slot_q[head_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	// Pointer and occupancy tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= (tail_q == PW'(DEPTH-1)) ? '0 : tail_q + 1'b1;
			end
			if (do_pop) begin
				head_q <= (head_q == PW'(DEPTH-1)) ? '0 : head_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[tail_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

### design/lkv_core.sv
// Cache core: key match, LRU ranking, replacement and value storage.
`default_nettype none

module lkv_core
	import lkv_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  cfg_wdata,
	input  wire logic              req_valid,
	input  wire req_t              req,
	input  wire logic              rsp_room,
	output logic                   req_pop,
	output logic                   rsp_valid,
	output rsp_t                   rsp
);

	localparam int RW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES+1);
	localparam int MW = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0] cap_q;
	logic [KEY_W-1:0] key_q [ENTRIES];
	logic [VAL_W-1:0] value_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [RW-1:0] rank_q [ENTRIES];
	logic [CW-1:0] fill_q;

	logic issue;
	logic [ENTRIES-1:0] match;
	logic any_hit;
	logic [RW-1:0] hit_idx;
	logic [RW-1:0] hit_rank;
	logic [MW-1:0] cap_ext;
	logic [CW-1:0] eff_cap;
	logic [CW-1:0] eff_cap_m1;
	logic evict;
	logic [ENTRIES-1:0] keep;
	logic [ENTRIES-1:0] free_vec;
	logic [ENTRIES-1:0] free_oh;
	logic [RW-1:0] free_idx;
	logic [RW-1:0] wr_idx;
	logic is_add;

	logic rsp_valid_s1;
	logic hit_s1;
	logic lookup_s1;
	logic [VAL_W-1:0] rdata_s1;

	assign issue = req_valid && rsp_room;
	assign req_pop = issue;
	assign is_add = (req.action == ACT_ADD);

	// Effective capacity: zero acts as one, clipped to the entry count.
	always_comb begin
		cap_ext = MW'(cap_q);
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (cap_ext > MW'(ENTRIES)) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = CW'(cap_ext);
		end
		eff_cap_m1 = eff_cap - 1'b1;
		evict = (fill_q >= eff_cap);
	end

	// Parallel key compare; the rank and index of the match are ORed out.
	always_comb begin
		hit_idx = '0;
		hit_rank = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == req.key);
			if (match[i]) begin
				hit_idx = hit_idx | RW'(i);
				hit_rank = hit_rank | rank_q[i];
			end
		end
		any_hit = |match;
	end

	// Entries that survive an insert, and the lowest free slot after it.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			keep[i] = valid_q[i] && !(evict && (CW'(rank_q[i]) >= eff_cap_m1));
		end
		free_vec = ~keep;
		free_oh = free_vec & (~free_vec + ENTRIES'(1));
		free_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (free_oh[i]) begin
				free_idx = free_idx | RW'(i);
			end
		end
		wr_idx = any_hit ? hit_idx : free_idx;
	end

	// Capacity register, valid bits, ranks and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			valid_q <= '0;
			fill_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (issue && any_hit) begin
				// Move the hit entry to the front; younger entries age by one.
				for (int i = 0; i < ENTRIES; i++) begin
					if (match[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
			end else if (issue && is_add) begin
				// Insert a new entry as most recent, evicting the oldest entries once the fill count reaches the capacity.
				for (int i = 0; i < ENTRIES; i++) begin
					if (free_oh[i]) begin
						rank_q[i] <= '0;
					end else if (keep[i]) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
				valid_q <= keep | free_oh;
				fill_q <= (evict ? eff_cap_m1 : fill_q) + 1'b1;
			end
		end
	end

	// Key registers, written at the slot an insert takes.
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (issue && is_add && !any_hit && free_oh[i]) begin
				key_q[i] <= req.key;
			end
		end
	end

	// Value memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (issue && is_add) begin
			value_mem[wr_idx] <= req.write_value;
		end
		if (issue) begin
			rdata_s1 <= value_mem[hit_idx];
		end
	end

	// Result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s1 <= 1'b0;
		end else begin
			rsp_valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			hit_s1 <= any_hit;
			lookup_s1 <= (req.action == ACT_LOOKUP);
		end
	end

	assign rsp_valid = rsp_valid_s1;
	assign rsp.hit = hit_s1;
	assign rsp.read_value = (hit_s1 && lookup_s1) ? rdata_s1 : '0;

	// The fill count matches the number of valid entries.
	a_fill_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(fill_q))
		else $error("fill count differs from valid entry count");

	// A key is never stored twice.
	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("key matched more than one entry");

	// A lookup miss leaves the valid bits and fill count alone.
	a_miss_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		issue && !any_hit && (req.action == ACT_LOOKUP) |=> $stable(valid_q) && $stable(fill_q))
		else $error("lookup miss changed the cache contents");

	// An insert always finds a free slot.
	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		issue && is_add && !any_hit |-> $onehot(free_oh))
		else $error("no free slot for insert");

endmodule

`default_nettype wire

### design/lru_key_value_cache.sv
// LRU key/value cache: top level with request queue, core and result queue.
//
// Usage: items enter through a queue-style port. An item is taken at a clock
// edge where push is high and full is low; action 0 adds key with write_value,
// action 1 looks key up. Each item produces exactly one result in order. A
// result waits on hit and read_value while empty is low and leaves at an edge
// where pop is high. The capacity register is written through cfg_we and
// cfg_wdata; the user must do so only while the cache is idle, as the block
// does not enforce it. It limits the entries in use before the least
// recently used one is replaced.
// Path: an accepted item passes the request queue, the core's result register
// and the result queue before its result shows.
// Throughput: one item per cycle while the result queue has room. The core
// handles each item with one parallel key compare and rank update, and
// registers its result together with the value memory read.
// Stalls: a four-entry result queue absorbs results; the core issues only when
// the queue has room counting the result in flight, and the two-entry request
// queue then fills and raises full.
// Reset: clears the queues, all valid bits, ranks and fill count, and sets
// capacity to eight. No clearing pass is needed.
`default_nettype none

module lru_key_value_cache
	import lkv_pkg::*;
#(
	parameter int ENTRIES = DEF_ENTRIES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  cfg_wdata,
	input  wire logic              push,
	output logic                   full,
	input  wire logic              action,
	input  wire logic [KEY_W-1:0]  key,
	input  wire logic [VAL_W-1:0]  write_value,
	output logic                   empty,
	input  wire logic              pop,
	output logic                   hit,
	output logic [VAL_W-1:0]       read_value
);

	localparam int OCW = $clog2(OUT_DEPTH+1);

	req_t req_in;
	req_t req_head;
	logic req_empty;
	logic req_pop;
	logic [$clog2(IN_DEPTH+1)-1:0] req_count;
	logic rsp_room;
	logic rsp_valid;
	rsp_t rsp_core;
	rsp_t rsp_head;
	logic rsp_full;
	logic [OCW-1:0] rsp_count;

	assign req_in.action = action;
	assign req_in.key = key;
	assign req_in.write_value = write_value;

	// Request queue.
	lkv_fifo #(
		.WIDTH ($bits(req_t)),
		.DEPTH (IN_DEPTH)
	) u_req_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (req_in),
		.full   (full),
		.pop    (req_pop),
		.rdata  (req_head),
		.empty  (req_empty),
		.count  (req_count)
	);

	// Room in the result queue, counting the result in flight.
	assign rsp_room = ((OCW+1)'(rsp_count) + (OCW+1)'(rsp_valid)) < (OCW+1)'(OUT_DEPTH);

	// Cache core.
	lkv_core #(
		.ENTRIES (ENTRIES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (!req_empty),
		.req       (req_head),
		.rsp_room  (rsp_room),
		.req_pop   (req_pop),
		.rsp_valid (rsp_valid),
		.rsp       (rsp_core)
	);

	// Result queue.
	lkv_fifo #(
		.WIDTH ($bits(rsp_t)),
		.DEPTH (OUT_DEPTH)
	) u_rsp_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rsp_valid),
		.wdata  (rsp_core),
		.full   (rsp_full),
		.pop    (pop),
		.rdata  (rsp_head),
		.empty  (empty),
		.count  (rsp_count)
	);

	assign hit = rsp_head.hit;
	assign read_value = rsp_head.read_value;

	// A result never arrives at a full result queue.
	a_no_rsp_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !rsp_full)
		else $error("result pushed into a full queue");

	// The request queue never reports more items than it holds.
	a_req_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'(req_count) <= IN_DEPTH)
		else $error("request queue count out of range");

	// Issue only happens with room for the result.
	a_issue_room: assert property (@(posedge clk) disable iff (!arst_n)
		req_pop |-> rsp_room && !req_empty)
		else $error("item issued without room for its result");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the LRU key/value cache.
`default_nettype none

module tb;
	import lkv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ENTRIES = DEF_ENTRIES;
	localparam int RANK_W = $clog2(NUM_ENTRIES);
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 128;
	localparam int POOL_SIZE = 12;

	// One row of the directed stimulus: an item, or a capacity write held in write_value.
	typedef enum logic {ROW_ITEM, ROW_CONFIG} row_kind_t;
	typedef struct {
		row_kind_t kind;
		logic act;
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		bit typed;
		rsp_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic push = 1'b0;
	logic full;
	logic action = ACT_ADD;
	logic [KEY_W-1:0] key = '0;
	logic [VAL_W-1:0] write_value = '0;
	logic empty;
	logic pop = 1'b0;
	logic hit;
	logic [VAL_W-1:0] read_value;

	// Typed-in response that goes with the item on the bus, when the row has one.
	bit row_typed = 1'b0;
	rsp_t row_want = '0;

	// Idle and stall rates in percent, and the receiver's hold-off counter.
	int send_idle_pct = 17;
	int recv_stall_pct = 17;
	int hold_cycles = 0;
	int failures = 0;

	// Responses the cache owes, oldest first.
	rsp_t awaited_responses[$];

	// Shadow copy of the cache contents and its capacity register.
	logic [KEY_W-1:0] m_key[NUM_ENTRIES];
	logic [VAL_W-1:0] m_value[NUM_ENTRIES];
	logic m_valid[NUM_ENTRIES];
	logic [RANK_W-1:0] m_rank[NUM_ENTRIES];
	logic [CAP_W-1:0] m_fill = '0;
	logic [CAP_W-1:0] m_capacity = CAP_RESET;

	stim_row_t directed_rows[28] = '{
		'{ROW_ITEM, ACT_LOOKUP, 16'h0000, 32'h00000000, 1'b1, {1'b0, 32'h00000000}},
		'{ROW_ITEM, ACT_LOOKUP, 16'hFFFF, 32'hFFFFFFFF, 1'b1, {1'b0, 32'h00000000}},
		'{ROW_ITEM, ACT_ADD,    16'h0000, 32'h00000000, 1'b1, {1'b0, 32'h00000000}},
		'{ROW_ITEM, ACT_ADD,    16'hFFFF, 32'hFFFFFFFF, 1'b1, {1'b0, 32'h00000000}},
		'{ROW_ITEM, ACT_LOOKUP, 16'hFFFF, 32'h00000000, 1'b1, {1'b1, 32'hFFFFFFFF}},
		'{ROW_ITEM, ACT_LOOKUP, 16'h0000, 32'h00000000, 1'b1, {1'b1, 32'h00000000}},
		'{ROW_ITEM, ACT_ADD,    16'h0000, 32'hA5A5A5A5, 1'b1, {1'b1, 32'h00000000}},
		'{ROW_ITEM, ACT_LOOKUP, 16'h0000, 32'h00000000, 1'b1, {1'b1, 32'hA5A5A5A5}},
		'{ROW_ITEM, ACT_ADD,    16'h0001, 32'h10000001, 1'b1, {1'b0, 32'h00000000}},
		'{ROW_ITEM, ACT_ADD,    16'h0002, 32'h20000002, 1'b1, {1'b0, 32'h00000000}},
		'{ROW_ITEM, ACT_ADD,    16'h0003, 32'h30000003, 1'b1, {1'b0, 32'h00000000}},
		'{ROW_ITEM, ACT_ADD,    16'h0004, 32'h40000004, 1'b1, {1'b0, 32'h00000000}},
		'{ROW_ITEM, ACT_ADD,    16'h0005, 32'h50000005, 1'b1, {1'b0, 32'h00000000}},
		'{ROW_ITEM, ACT_ADD,    16'h0006, 32'h60000006, 1'b1, {1'b0, 32'h00000000}},
		// The table is full here, so this add replaces the least recent entry.
		'{ROW_ITEM, ACT_ADD,    16'h0007, 32'h5A5A5A5A, 1'b1, {1'b0, 32'h00000000}},
		'{ROW_ITEM, ACT_LOOKUP, 16'hFFFF, 32'h00000000, 1'b0, '0},
		'{ROW_ITEM, ACT_LOOKUP, 16'h0000, 32'h00000000, 1'b0, '0},
		'{ROW_ITEM, ACT_LOOKUP, 16'h0001, 32'h00000000, 1'b0, '0},
		'{ROW_ITEM, ACT_ADD,    16'h0008, 32'h80000001, 1'b0, '0},
		'{ROW_ITEM, ACT_LOOKUP, 16'h0002, 32'h00000000, 1'b0, '0},
		// Capacity lowered below the fill count: lookups still see every entry.
		'{ROW_CONFIG, ACT_ADD,  16'h0000, 32'h00000003, 1'b0, '0},
		'{ROW_ITEM, ACT_LOOKUP, 16'h0008, 32'h00000000, 1'b0, '0},
		'{ROW_ITEM, ACT_ADD,    16'h1234, 32'h13572468, 1'b0, '0},
		'{ROW_ITEM, ACT_LOOKUP, 16'h0000, 32'h00000000, 1'b0, '0},
		// A capacity of zero acts as one, and one above the table size as the size.
		'{ROW_CONFIG, ACT_ADD,  16'h0000, 32'h00000000, 1'b0, '0},
		'{ROW_ITEM, ACT_ADD,    16'hBEEF, 32'h0BADF00D, 1'b0, '0},
		'{ROW_ITEM, ACT_LOOKUP, 16'h0008, 32'h00000000, 1'b0, '0},
		'{ROW_CONFIG, ACT_ADD,  16'h0000, 32'h0000000F, 1'b0, '0}
	};

	lru_key_value_cache #(
		.ENTRIES(NUM_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.push(push),
		.full(full),
		.action(action),
		.key(key),
		.write_value(write_value),
		.empty(empty),
		.pop(pop),
		.hit(hit),
		.read_value(read_value)
	);

	always #4 clk = ~clk;

	// Applies one item to the shadow cache and returns the response it should give.
	function automatic rsp_t predict_response(input logic act, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		rsp_t r;
		int slot;
		int free_slot;
		int unsigned cap;
		logic [RANK_W-1:0] old_rank;
		r = '0;
		slot = -1;
		free_slot = -1;
		for (int i = 0; i < NUM_ENTRIES; i++)
			if (slot < 0 && m_valid[i] && m_key[i] == k) slot = i;
		if (slot >= 0) begin
			// Present key: update or read it, then move it to the front.
			if (act == ACT_ADD) m_value[slot] = v;
			else r.read_value = m_value[slot];
			r.hit = 1'b1;
			old_rank = m_rank[slot];
			for (int i = 0; i < NUM_ENTRIES; i++)
				if (m_valid[i] && m_rank[i] < old_rank) m_rank[i] = m_rank[i] + 1'b1;
			m_rank[slot] = '0;
		end else if (act == ACT_ADD) begin
			// New key: drop the oldest entries once the capacity is reached.
			cap = (m_capacity == 0) ? 1 : (m_capacity > NUM_ENTRIES) ? NUM_ENTRIES : m_capacity;
			if (m_fill >= cap) begin
				for (int i = 0; i < NUM_ENTRIES; i++)
					if (m_valid[i] && m_rank[i] >= cap - 1) m_valid[i] = 1'b0;
				m_fill = CAP_W'(cap - 1);
			end
			// The lowest free slot takes the new key as most recent.
			for (int i = NUM_ENTRIES - 1; i >= 0; i--)
				if (!m_valid[i]) free_slot = i;
			for (int i = 0; i < NUM_ENTRIES; i++)
				if (m_valid[i]) m_rank[i] = m_rank[i] + 1'b1;
			m_key[free_slot] = k;
			m_value[free_slot] = v;
			m_valid[free_slot] = 1'b1;
			m_rank[free_slot] = '0;
			m_fill = m_fill + 1'b1;
		end
		return r;
	endfunction

	// Offers one item after a random gap and returns at the falling edge after it is taken.
	task automatic offer_item(input logic act, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v, input bit typed, input rsp_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		action = act;
		key = k;
		write_value = v;
		row_typed = typed;
		row_want = want;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	// Stops offering and waits until every owed response has come back.
	task automatic wait_drained();
		push = 1'b0;
		while (awaited_responses.size() != 0) @(negedge clk);
	endtask

	// Capacity writes happen only while the cache holds no work.
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		wait_drained();
		cfg_we = 1'b1;
		cfg_wdata = cap;
		@(negedge clk);
		cfg_we = 1'b0;
		m_capacity = cap;
	endtask

	// Receiver side: a long hold-off when asked, random stalls otherwise.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			pop = 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			pop = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Record accepted items and check accepted responses at the rising edge.
	always @(posedge clk) begin
		rsp_t due;
		if (arst_n && push && !full) begin
			due = predict_response(action, key, write_value);
			if (row_typed) due = row_want;
			awaited_responses.push_back(due);
		end
		if (arst_n && pop && !empty) begin
			if (awaited_responses.size() == 0) begin
				$error("response with nothing owed: hit=%0d read_value=%h", hit, read_value);
				failures++;
			end else begin
				due = awaited_responses.pop_front();
				if (hit !== due.hit) begin
					$error("hit: expected %0d, got %0d", due.hit, hit);
					failures++;
				end
				if (read_value !== due.read_value) begin
					$error("read_value: expected %h, got %h", due.read_value, read_value);
					failures++;
				end
			end
		end
	end

	// Main sequence: reset, directed rows, then random phases.
	initial begin
		logic [KEY_W-1:0] key_pool[POOL_SIZE];
		logic [CAP_W-1:0] phase_capacity[PHASES];
		int send_plan[4];
		int recv_plan[4];
		logic [KEY_W-1:0] k;
		logic act;
		phase_capacity = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd2, 4'd5, 4'd11, 4'd7};
		send_plan = '{0, 64, 0, 17};
		recv_plan = '{0, 0, 64, 17};
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			m_valid[i] = 1'b0;
			m_rank[i] = '0;
			m_key[i] = '0;
			m_value[i] = '0;
		end

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows.
		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_CONFIG)
				write_capacity(directed_rows[r].v[CAP_W-1:0]);
			else
				offer_item(directed_rows[r].act, directed_rows[r].k, directed_rows[r].v,
					directed_rows[r].typed, directed_rows[r].want);
		end

		// Random phases over capacities and idle mixes; keys mostly from a small pool.
		for (int p = 0; p < PHASES; p++) begin
			write_capacity(phase_capacity[p]);
			send_idle_pct = send_plan[p % 4];
			recv_stall_pct = recv_plan[p % 4];
			// In the first phase the receiver holds off so the cache fills and stalls.
			if (p == 0) hold_cycles = 150;
			key_pool[0] = '0;
			key_pool[1] = '1;
			for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom_range(16'hFFFF));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(9) == 0) k = KEY_W'($urandom_range(16'hFFFF));
				else k = key_pool[$urandom_range(POOL_SIZE - 1)];
				act = ($urandom_range(99) < 55) ? ACT_LOOKUP : ACT_ADD;
				offer_item(act, k, $urandom, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (8) @(negedge clk);
		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#3ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

### lru_key_value_cache.f
design/lkv_pkg.sv
design/lkv_fifo.sv
design/lkv_core.sv
design/lru_key_value_cache.sv
tb/tb.sv
